>>> rtl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and constants for the triangle tangent calculator.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned TexW    = 24;
  localparam int unsigned EdgeW   = 33;
  localparam int unsigned DuvW    = 25;
  localparam int unsigned DetW    = 51;
  localparam int unsigned NumW    = 59;
  localparam int unsigned FactorW = 40;
  localparam int unsigned ThrW    = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 40;
  localparam int unsigned QuoW    = 49;
  localparam int unsigned AccW    = NumW + FactorW;

  localparam logic [CfgIdxW-1:0] CfgDetThreshold  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFallbackFactor = 1'b1;

  localparam logic [ThrW-1:0]    ThrReset    = 32'd512;
  localparam logic [FactorW-1:0] FactorReset = 40'd6553600000;
  localparam logic [FactorW-1:0] FactorMax   = '1;

  typedef enum logic [3:0] {
    OpNone,
    OpSave,
    OpDelta,
    OpDet,
    OpNum,
    OpDivStep,
    OpMulStep,
    OpScale,
    OpOut
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
    logic [1:0] part;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

>>> rtl/ttc_ctrl.sv
// ----------------------------------------------------------------------------
// ttc_ctrl
// Sequencer: save corners, compute deltas, divide, scale, emit three results.
// ----------------------------------------------------------------------------
module ttc_ctrl
  import ttc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output logic [1:0] out_k_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    StIdle, StDelta, StDet, StDiv, StNum, StMul, StScale, StOut
  } state_e;

  state_e     state_q;
  logic [1:0] corner_q, sub_q, k_q, part_q;
  logic       in_fire, out_fire;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_k_o     = k_q;

  always_comb begin
    cmd_o.op   = OpNone;
    cmd_o.sel  = sub_q;
    cmd_o.part = part_q;
    case (state_q)
      StIdle:  cmd_o.op = in_fire ? OpSave : OpNone;
      StDelta: cmd_o.op = OpDelta;
      StDet:   cmd_o.op = OpDet;
      StDiv:   cmd_o.op = OpDivStep;
      StNum:   cmd_o.op = OpNum;
      StMul:   cmd_o.op = OpMulStep;
      StScale: cmd_o.op = OpScale;
      StOut:   cmd_o.op = OpOut;
      default: cmd_o.op = OpNone;
    endcase
    if (state_q == StIdle) cmd_o.sel = corner_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      corner_q <= '0;
      sub_q    <= '0;
      k_q      <= '0;
      part_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (corner_q == 2'd2) begin
              corner_q <= '0;
              state_q  <= StDelta;
            end else begin
              corner_q <= corner_q + 2'd1;
            end
          end
        end
        StDelta: state_q <= StDet;
        StDet:   state_q <= StDiv;
        StDiv:   if (sts_i.div_done) begin
          state_q <= StNum;
          sub_q   <= '0;
        end
        StNum: begin
          state_q <= StMul;
          part_q  <= '0;
        end
        StMul: begin
          if (part_q == 2'd3) begin
            part_q  <= '0;
            state_q <= StScale;
          end else begin
            part_q  <= part_q + 2'd1;
          end
        end
        StScale: begin
          if (sub_q == 2'd3) begin
            sub_q   <= '0;
            state_q <= StOut;
            k_q     <= '0;
          end else if (sub_q == 2'd2) begin
            sub_q   <= 2'd3;
          end else begin
            sub_q   <= sub_q + 2'd1;
            state_q <= StMul;
          end
        end
        StOut: begin
          if (out_fire) begin
            if (k_q == 2'd2) begin
              state_q <= StIdle;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> rtl/ttc_dp.sv
// ----------------------------------------------------------------------------
// ttc_dp
// Datapath: corner storage, deltas, determinant, restoring divider, scaling.
// ----------------------------------------------------------------------------
module ttc_dp
  import ttc_pkg::*;
#(
  parameter int unsigned IndexBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  output dp_sts_t                     sts_o,
  input  logic [ThrW-1:0]             thr_i,
  input  logic [FactorW-1:0]          fallback_i,
  input  logic [IndexBits-1:0]        idx_i,
  input  logic signed [PosW-1:0]      px_i,
  input  logic signed [PosW-1:0]      py_i,
  input  logic signed [PosW-1:0]      pz_i,
  input  logic signed [TexW-1:0]      u_i,
  input  logic signed [TexW-1:0]      v_i,
  input  logic [1:0]                  k_i,
  output logic [IndexBits-1:0]        idx_o,
  output logic signed [PosW-1:0]      tx_o,
  output logic signed [PosW-1:0]      ty_o,
  output logic signed [PosW-1:0]      tz_o
);

  logic signed [PosW-1:0]  pos_q [3][3];
  logic signed [TexW-1:0]  tex_q [3][2];
  logic [IndexBits-1:0]    idx_q [3];
  logic signed [EdgeW-1:0] e1_q [3], e2_q [3];
  logic signed [DuvW-1:0]  du1_q, dv1_q, du2_q, dv2_q;
  logic signed [DetW-1:0]  det_q;
  logic signed [NumW-1:0]  num_q [3];
  logic [FactorW-1:0]      factor_q;
  logic signed [PosW-1:0]  t_q [3];
  logic [DetW-2:0]         rem_q;
  logic [QuoW-1:0]         quo_q;
  logic [5:0]              cnt_q;
  logic                    use_div_q;
  logic [AccW-1:0]         acc_q;

  logic signed [DetW-1:0] det_d;
  logic [DetW-1:0]   rem_sh;
  logic [DetW-1:0]   dval;
  logic              ge;
  logic [1:0]        sel;
  logic [1:0]        nsel;
  logic [1:0]        part;
  logic [NumW-1:0]   nmag;
  logic              nneg;
  logic [29:0]       mul_a;
  logic [19:0]       mul_b;
  logic [49:0]       pp;
  logic [AccW-1:0]   pp_sh;
  logic [AccW-33:0]  mag;
  logic signed [PosW-1:0]  sat;
  logic [5:0]        bitpos;

  assign sel    = cmd_i.sel;
  assign part   = cmd_i.part;
  assign det_d  = DetW'(du1_q * dv2_q) - DetW'(du2_q * dv1_q);
  assign dval   = {1'b0, det_q[DetW-2:0]};
  assign bitpos = 6'(QuoW - 1) - cnt_q;
  assign rem_sh = {rem_q, (bitpos == 6'd48)};
  assign ge     = rem_sh >= dval;
  assign sts_o.div_done = !use_div_q || (cnt_q == 6'(QuoW));

  always_comb begin
    nsel  = (sel == 2'd3) ? 2'd2 : sel;
    nneg  = num_q[nsel][NumW-1];
    nmag  = nneg ? NumW'(-num_q[nsel]) : NumW'(num_q[nsel]);
    mul_a = part[1] ? nmag[NumW-1:29] : {1'b0, nmag[28:0]};
    mul_b = part[0] ? factor_q[FactorW-1:20] : factor_q[19:0];
    pp    = 50'(mul_a) * 50'(mul_b);
    case (part)
      2'd0:    pp_sh = AccW'(pp);
      2'd1:    pp_sh = AccW'(pp) << 20;
      2'd2:    pp_sh = AccW'(pp) << 29;
      default: pp_sh = AccW'(pp) << 49;
    endcase
    mag  = acc_q[AccW-1:32];
    if (nneg) begin
      sat = (mag >= (AccW-32)'(32'h8000_0000)) ? $signed(32'h8000_0000)
                                               : -$signed(PosW'(mag));
    end else begin
      sat = (mag > (AccW-32)'(32'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF)
                                              : $signed(PosW'(mag));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      use_div_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OpDet: begin
          use_div_q <= det_d > $signed({{(DetW-ThrW){1'b0}}, thr_i});
          cnt_q     <= '0;
        end
        OpDivStep: if (use_div_q && cnt_q != 6'(QuoW)) cnt_q <= cnt_q + 6'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpSave: begin
        pos_q[sel][0] <= px_i;
        pos_q[sel][1] <= py_i;
        pos_q[sel][2] <= pz_i;
        tex_q[sel][0] <= u_i;
        tex_q[sel][1] <= v_i;
        idx_q[sel]    <= idx_i;
      end
      OpDelta: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EdgeW'(pos_q[1][i]) - EdgeW'(pos_q[0][i]);
          e2_q[i] <= EdgeW'(pos_q[2][i]) - EdgeW'(pos_q[0][i]);
        end
        du1_q <= DuvW'(tex_q[1][0]) - DuvW'(tex_q[0][0]);
        dv1_q <= DuvW'(tex_q[1][1]) - DuvW'(tex_q[0][1]);
        du2_q <= DuvW'(tex_q[2][0]) - DuvW'(tex_q[0][0]);
        dv2_q <= DuvW'(tex_q[2][1]) - DuvW'(tex_q[0][1]);
      end
      OpDet: begin
        det_q <= det_d;
        rem_q <= '0;
        quo_q <= '0;
      end
      OpDivStep: begin
        if (use_div_q && cnt_q != 6'(QuoW)) begin
          rem_q <= ge ? (DetW-1)'(rem_sh - dval) : rem_sh[DetW-2:0];
          quo_q <= {quo_q[QuoW-2:0], ge};
        end
      end
      OpNum: begin
        for (int i = 0; i < 3; i++) begin
          num_q[i] <= NumW'(dv2_q * e1_q[i]) - NumW'(dv1_q * e2_q[i]);
        end
        if (!use_div_q) factor_q <= fallback_i;
        else if (quo_q[QuoW-1:FactorW] != '0) factor_q <= FactorMax;
        else factor_q <= quo_q[FactorW-1:0];
      end
      OpMulStep: begin
        acc_q <= (part == 2'd0) ? pp_sh : acc_q + pp_sh;
      end
      OpScale: begin
        if (sel != 2'd3) t_q[sel] <= sat;
        else if (t_q[0] == '0 && t_q[1] == '0 && t_q[2] == '0)
          t_q[0] <= 32'sd65536;
      end
      default: ;
    endcase
  end

  assign idx_o = idx_q[k_i];
  assign tx_o  = t_q[0];
  assign ty_o  = t_q[1];
  assign tz_o  = t_q[2];

endmodule

>>> rtl/triangle_tangent_calculator_unit.sv
// ----------------------------------------------------------------------------
// triangle_tangent_calculator_unit
// Per-triangle tangent from a stream of indexed corners.
// ----------------------------------------------------------------------------
// Corners one and two are only stored. The third corner starts the work:
// deltas, determinant, a 49-step restoring divider (bypassed when the
// fallback factor applies) and three scaling multiplies of four partial
// products each plus a write-back; then three results are offered, one per
// corner. Input is held off from the third corner until the last result
// transfers.
module triangle_tangent_calculator_unit
  import ttc_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDatW-1:0]       cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [INDEX_BITS-1:0]    vertex_index_i,
  input  logic signed [PosW-1:0]   pos_x_i,
  input  logic signed [PosW-1:0]   pos_y_i,
  input  logic signed [PosW-1:0]   pos_z_i,
  input  logic signed [TexW-1:0]   tex_u_i,
  input  logic signed [TexW-1:0]   tex_v_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [INDEX_BITS-1:0]    target_index_o,
  output logic signed [PosW-1:0]   tangent_x_o,
  output logic signed [PosW-1:0]   tangent_y_o,
  output logic signed [PosW-1:0]   tangent_z_o,
  output logic                     last_of_triangle_o
);

  logic [ThrW-1:0]    thr_q;
  logic [FactorW-1:0] fb_q;
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [1:0]         k;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      fb_q  <= FactorReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDetThreshold:   thr_q <= cfg_data_i[ThrW-1:0];
        CfgFallbackFactor: fb_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ttc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_k_o     (k),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ttc_dp #(.IndexBits(INDEX_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .thr_i      (thr_q),
    .fallback_i (fb_q),
    .idx_i      (vertex_index_i),
    .px_i       (pos_x_i),
    .py_i       (pos_y_i),
    .pz_i       (pos_z_i),
    .u_i        (tex_u_i),
    .v_i        (tex_v_i),
    .k_i        (k),
    .idx_o      (target_index_o),
    .tx_o       (tangent_x_o),
    .ty_o       (tangent_y_o),
    .tz_o       (tangent_z_o)
  );

  assign last_of_triangle_o = out_valid_o && (k == 2'd2);

endmodule

>>> rtl/ttc_checker.sv
// ----------------------------------------------------------------------------
// ttc_checker
// Port-level checks for the triangle tangent calculator.
// ----------------------------------------------------------------------------
module ttc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic last_of_triangle_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output both open");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_of_triangle_o |=> !out_valid_o)
    else $error("output after last of triangle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("valid dropped");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i) else $error("input valid dropped");

  a_last_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_triangle_o |-> out_valid_o) else $error("last without valid");

endmodule

bind triangle_tangent_calculator_unit ttc_checker u_ttc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .last_of_triangle_o (last_of_triangle_o)
);
